// ===== rtl/rdq_pkg.sv =====
// shared constants, codes and control types for the reversible deque
`default_nettype none

package rdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int WORD_W = 32;

    // fixed field widths
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 11;

    // stream widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = ACT_W;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = STAT_W;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(DEPTH);

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REVERSE    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_VALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic capture;
    } rdq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_read;
    } rdq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rdq_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rdq_ctrl.sv =====
// sequencing state machine for the reversible deque
`default_nettype none

module rdq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire rdq_pkg::rdq_stat_t stat,
    output rdq_pkg::rdq_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.take    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = stat.needs_read ? S_READ : S_SEND;
                end
            end
            S_READ:
            begin
                // ram data is out now
                cmd.capture = 1'b1;
                state_next  = S_SEND;
            end
            S_SEND:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rdq_datapath.sv =====
// pointers, count, orientation, word store and result registers
`default_nettype none

module rdq_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [rdq_pkg::S_USER_W-1:0]   s_tuser,
    input  wire logic [rdq_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire rdq_pkg::rdq_cmd_t              cmd,
    output rdq_pkg::rdq_stat_t                  stat,
    output logic      [rdq_pkg::M_USER_W-1:0]   m_tuser,
    output logic      [rdq_pkg::M_DATA_W-1:0]   m_tdata
);

    logic [rdq_pkg::ADDR_W-1:0] head_reg;
    logic [rdq_pkg::ADDR_W-1:0] head_next;
    logic [rdq_pkg::CNT_W-1:0]  count_reg;
    logic [rdq_pkg::CNT_W-1:0]  count_next;
    logic                       rev_reg;
    logic                       rev_next;

    logic [rdq_pkg::STAT_W-1:0] status_reg;
    logic [rdq_pkg::STAT_W-1:0] status_next;
    logic [rdq_pkg::WORD_W-1:0] popped_reg;
    logic [rdq_pkg::OCC_W-1:0]  occ_reg;

    logic [rdq_pkg::ADDR_W-1:0] head_inc;
    logic [rdq_pkg::ADDR_W-1:0] head_dec;
    logic [rdq_pkg::SUM_W-1:0]  tail_sum;
    logic [rdq_pkg::ADDR_W-1:0] tail;
    logic [rdq_pkg::ADDR_W-1:0] back;
    logic                       empty;
    logic                       full;
    logic                       phys_front;

    logic                       ram_we;
    logic [rdq_pkg::ADDR_W-1:0] ram_waddr;
    logic                       ram_re;
    logic [rdq_pkg::ADDR_W-1:0] ram_raddr;
    logic [rdq_pkg::WORD_W-1:0] ram_rdata;

    // circular index arithmetic, one compare per wrap
    always_comb
    begin
        head_inc = (head_reg == rdq_pkg::LAST_IDX) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? rdq_pkg::LAST_IDX : head_reg - 1'b1;
        tail_sum = rdq_pkg::SUM_W'(head_reg) + rdq_pkg::SUM_W'(count_reg);
        if (tail_sum >= rdq_pkg::DEPTH_S)
        begin
            tail = rdq_pkg::ADDR_W'(tail_sum - rdq_pkg::DEPTH_S);
        end
        else
        begin
            tail = rdq_pkg::ADDR_W'(tail_sum);
        end
        back = (tail == '0) ? rdq_pkg::LAST_IDX : tail - 1'b1;
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg >= rdq_pkg::DEPTH_C);

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        status_next     = rdq_pkg::ST_DONE;
        ram_we          = 1'b0;
        ram_waddr       = tail;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;
        stat.needs_read = 1'b0;
        phys_front      = 1'b0;
        case (s_tuser)
            rdq_pkg::ACT_PUSH_FRONT, rdq_pkg::ACT_PUSH_BACK:
            begin
                phys_front = (s_tuser == rdq_pkg::ACT_PUSH_FRONT) != rev_reg;
                if (full)
                begin
                    status_next = rdq_pkg::ST_FULL;
                end
                else
                begin
                    ram_we     = cmd.take;
                    count_next = count_reg + 1'b1;
                    if (phys_front)
                    begin
                        head_next = head_dec;
                        ram_waddr = head_dec;
                    end
                end
            end
            rdq_pkg::ACT_POP_FRONT, rdq_pkg::ACT_POP_BACK:
            begin
                phys_front = (s_tuser == rdq_pkg::ACT_POP_FRONT) != rev_reg;
                if (empty)
                begin
                    status_next = rdq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next     = rdq_pkg::ST_VALID;
                    stat.needs_read = 1'b1;
                    ram_re          = cmd.take;
                    count_next      = count_reg - 1'b1;
                    if (phys_front)
                    begin
                        head_next = head_inc;
                    end
                    else
                    begin
                        ram_raddr = back;
                    end
                end
            end
            rdq_pkg::ACT_REVERSE:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
                // undefined actions leave everything alone
                status_next = rdq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (cmd.take)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            status_reg <= status_next;
            popped_reg <= '0;
            occ_reg    <= rdq_pkg::OCC_W'(count_next);
        end
        else if (cmd.capture)
        begin
            popped_reg <= ram_rdata;
        end
    end

    rdq_ram #(
        .WIDTH (rdq_pkg::WORD_W),
        .DEPTH (rdq_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tuser = status_reg;
    assign m_tdata = {
        (rdq_pkg::M_DATA_W - rdq_pkg::OCC_W - rdq_pkg::WORD_W)'(0),
        occ_reg,
        popped_reg
    };

endmodule

`default_nettype wire

// ===== rtl/reversible_deque.sv =====
// result: a push, reverse or failed pop shows its result in the cycle after accept;
// a pop that returns a word goes through the registered store read and S_READ first
// ordering: no new item is taken before the last result is handed off, since
// the controller holds one item from accept to result handoff
// reset: rst_n low clears head, count, orientation and the controller;
// the word store is not cleared and needs no clearing pass
`default_nettype none

module reversible_deque (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rdq_pkg::S_DATA_W-1:0] s_tdata,  // push_value[31:0]
    input  wire logic [rdq_pkg::S_USER_W-1:0] s_tuser,  // action[2:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [rdq_pkg::M_DATA_W-1:0] m_tdata,  // popped_value[31:0], occupancy[42:32]
    output logic      [rdq_pkg::M_USER_W-1:0] m_tuser   // status[1:0]
);

    rdq_pkg::rdq_cmd_t  cmd;
    rdq_pkg::rdq_stat_t stat;

    rdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/rdq_checker.sv =====
// port level checks for the reversible deque, bound to the top level
`default_nettype none

module rdq_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [rdq_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [rdq_pkg::M_USER_W-1:0] m_tuser
);

    // no result pending out of reset
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // one item in flight: no accept while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // occupancy never exceeds the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[42:32] <= rdq_pkg::OCC_W'(rdq_pkg::DEPTH)))
        else $error("occupancy above depth");

    // only a successful pop carries a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != rdq_pkg::ST_VALID)) |-> (m_tdata[31:0] == '0))
        else $error("nonzero popped word without pop");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/reversible_deque_test.sv =====
// self-checking stream testbench for the reversible deque with a shadow queue predictor
module reversible_deque_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdq_pkg::*;

    // undefined action codes, the block must ignore them
    localparam logic [ACT_W-1:0] ACT_RSVD_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;

    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_AFTER  = 300;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] popped;
        logic [OCC_W-1:0]  occ;
    } deque_result_t;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] val;
        logic              typed;
        deque_result_t     want;
    } directed_row_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    // shadow copy of the deque
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                shadow_head  = 0;
    int                shadow_count = 0;
    bit                shadow_rev   = 1'b0;

    deque_result_t pending_results [$];
    int            error_count   = 0;
    int            results_seen  = 0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            hold_left     = 0;
    bit            hold_used     = 1'b0;

    directed_row_t script [0:22] = '{
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 11'd0}},
        '{ACT_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'h0, 11'd0}},
        '{ACT_REVERSE,    32'h0000_0000, 1'b1, '{ST_DONE,  32'h0, 11'd0}},
        '{ACT_REVERSE,    32'h0000_0000, 1'b1, '{ST_DONE,  32'h0, 11'd0}},
        '{ACT_RSVD_5,     32'h1234_5678, 1'b1, '{ST_DONE,  32'h0, 11'd0}},
        '{ACT_RSVD_7,     32'hFFFF_FFFF, 1'b1, '{ST_DONE,  32'h0, 11'd0}},
        '{ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{ST_DONE,  32'h0, 11'd1}},
        '{ACT_PUSH_BACK,  32'h8000_0000, 1'b1, '{ST_DONE,  32'h0, 11'd2}},
        '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{ST_DONE,  32'h0, 11'd3}},
        '{ACT_PUSH_BACK,  32'h0000_0000, 1'b1, '{ST_DONE,  32'h0, 11'd4}},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{ACT_REVERSE,    32'h0000_0000, 1'b0, '0},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{ACT_RSVD_6,     32'h8765_4321, 1'b0, '0},
        '{ACT_REVERSE,    32'h0000_0000, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 11'd0}},
        '{ACT_PUSH_BACK,  32'h0000_0001, 1'b1, '{ST_DONE,  32'h0, 11'd1}}
    };

    reversible_deque DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // applies one action to the shadow deque and returns what the block should answer
    function automatic deque_result_t apply_action(logic [ACT_W-1:0] act,
                                                   logic [WORD_W-1:0] val);
        deque_result_t r;
        bit            at_phys_front;
        int            slot;
        r = '0;
        r.status = ST_DONE;
        // orientation flips which physical end a logical front action touches
        at_phys_front = ((act == ACT_PUSH_FRONT) || (act == ACT_POP_FRONT)) != shadow_rev;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (at_phys_front)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        slot = shadow_head;
                    end
                    else
                        slot = (shadow_head + shadow_count) % DEPTH;
                    shadow_words[slot] = val;
                    shadow_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (at_phys_front)
                    begin
                        slot = shadow_head;
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end
                    else
                        slot = (shadow_head + shadow_count - 1) % DEPTH;
                    r.popped = shadow_words[slot];
                    r.status = ST_VALID;
                    shadow_count--;
                end
            end
            ACT_REVERSE:
                shadow_rev = !shadow_rev;
            default:
                ;
        endcase
        r.occ = OCC_W'(shadow_count);
        return r;
    endfunction

    function automatic logic [ACT_W-1:0] draw_action(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        if ($urandom_range(0, 3) != 0)
            return ACT_REVERSE;
        case ($urandom_range(0, 2))
            0:       return ACT_RSVD_5;
            1:       return ACT_RSVD_6;
            default: return ACT_RSVD_7;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // offers one item, waits for the handshake and records the expected result
    task automatic offer_item(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val,
                              input bit typed, input deque_result_t typed_want);
        deque_result_t calc;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        calc = apply_action(act, val);
        pending_results.push_back(typed ? typed_want : calc);
    endtask

    task automatic run_mix(input int n, input int push_pct, input int pop_pct);
        repeat (n)
            offer_item(draw_action(push_pct, pop_pct), draw_word(), 1'b0, '0);
    endtask

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        error_count++;
    endtask

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && results_seen >= HOLD_AFTER)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, status %0d popped %h occupancy %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[42:32]);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[31:0] !== want.popped)
                    report_mismatch("popped_value", want.popped, m_tdata[31:0]);
                if (m_tdata[42:32] !== want.occ)
                    report_mismatch("occupancy", 32'(want.occ), 32'(m_tdata[42:32]));
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer_item(script[i].act, script[i].val, script[i].typed, script[i].want);

        // near empty, pops often find nothing
        send_idle_pct = 0;
        stall_pct     = 0;
        run_mix(30, 40, 45);

        // fill to the top, idling moves from sender to receiver to both as it fills
        while (shadow_count < DEPTH)
        begin
            if (shadow_count < DEPTH / 3)
            begin
                send_idle_pct = 58;
                stall_pct     = 0;
            end
            else if (shadow_count < 2 * DEPTH / 3)
            begin
                send_idle_pct = 0;
                stall_pct     = 58;
            end
            else
            begin
                send_idle_pct = 38;
                stall_pct     = 38;
            end
            offer_item(draw_action(98, 1), draw_word(), 1'b0, '0);
        end

        // work around the full boundary, then drain part of it
        run_mix(30, 55, 40);
        stall_pct = 58;
        run_mix(20, 20, 70);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/rdq_ctrl.sv
rtl/rdq_datapath.sv
rtl/reversible_deque.sv
rtl/rdq_checker.sv
tb/sv/reversible_deque_test.sv
